>>> rtl/lbs_pkg.sv
// Shared types, constants and small functions of the LED blink scheduler table.
`default_nettype none
package lbs_pkg;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic [7:0]  led_index;
    logic [3:0]  anim_mode;
    logic [7:0]  fade_in;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  duty_adjust;
    logic [7:0]  period_adjust;
  } lbs_in_t;

  typedef struct packed {
    logic [7:0] led_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] fade_out;
    logic       last;
  } lbs_out_t;

  typedef struct packed {
    logic [7:0]  led;
    logic [3:0]  mode;
    logic        phase;
    logic [31:0] color_fade;
    logic [15:0] adjusts;
    logic [31:0] deadline;
    logic [11:0] on_time;
    logic [11:0] off_time;
  } lbs_entry_t;

  // Head entry shown to every cell while group ranks are counted.
  typedef struct packed {
    logic       valid;
    logic [7:0] led;
    logic [3:0] mode;
  } lbs_bcast_t;

  localparam logic [3:0] MODE_STOP    = 4'd0;
  localparam logic [3:0] MODE_BURST   = 4'd5;
  localparam logic [3:0] MODE_MQ_DESC = 4'd6;
  localparam logic [3:0] MODE_MQ_ASC  = 4'd7;
  localparam logic [3:0] MODE_MQ_ADJ  = 4'd8;

  localparam int DIV_AW = 19;
  localparam int DIV_BW = 8;

  localparam logic [10:0] T_SPAN    = 11'd1500;
  localparam logic [10:0] T_HALF    = 11'd750;
  localparam logic [10:0] T_PERIOD  = 11'd2000;
  localparam logic [7:0]  ADJ_FULL  = 8'd255;
  localparam logic [7:0]  FADE_DARK = 8'd255;

  // Reciprocal of 255 scaled by 2**31, rounded up.
  localparam logic [42:0] RCP_255 = 43'h808081;

  function automatic logic [11:0] half_period(input logic [3:0] mode);
    logic [11:0] r;
    case (mode)
      4'd1:       r = 12'd1000;
      4'd2:       r = 12'd750;
      4'd3:       r = 12'd500;
      4'd4:       r = 12'd250;
      MODE_BURST: r = 12'd2500;
      default:    r = 12'd0;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] burst_next(input logic [11:0] v);
    logic [11:0] r;
    case (v)
      12'd2500: r = 12'd102;
      12'd102:  r = 12'd101;
      12'd101:  r = 12'd100;
      12'd100:  r = 12'd99;
      12'd99:   r = 12'd98;
      12'd98:   r = 12'd2500;
      default:  r = v;
    endcase
    return r;
  endfunction

  // Floor of x / 255 for any x below 255 * 2**11; only 11 quotient bits are returned.
  function automatic logic [10:0] div255(input logic [DIV_AW-1:0] x);
    logic [42:0] pr;
    pr = 43'(x) * RCP_255;
    return pr[41:31];
  endfunction

endpackage
`default_nettype wire

>>> rtl/led_blink_scheduler_table.sv
// Top level: rotating ring of timer cells and the sequencer working at its head.
//
//   port group | dir | transfer when
//   in_*       | in  | in_valid && !in_stall   (tick or start/stop item)
//   out_*      | out | out_valid && !out_stall (one LED write)
//
// Every pass rotates the ring once, one entry at the head per cycle unless an output
// stall holds the tick pass. A tick is one pass and then a flush of the held write.
// A start takes one or two removal passes, an append pass if mode and room allow, and per
// marquee rebuild a clear step, a rank pass, a timing step (direct for a group of one in
// modes 6 and 7, else a 1500/n divide there, reciprocal multiplies in mode 8) and an
// apply pass. Reset empties the table at once; in_stall is high whenever an item is at work.
`default_nettype none
module led_blink_scheduler_table #(
  parameter int ENTRIES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lbs_pkg::lbs_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lbs_pkg::lbs_out_t       out_data
);

  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TICK   = 4'd1;
  localparam logic [3:0] S_FLUSH  = 4'd2;
  localparam logic [3:0] S_REMA   = 4'd3;
  localparam logic [3:0] S_REMB   = 4'd4;
  localparam logic [3:0] S_APPEND = 4'd5;
  localparam logic [3:0] S_BCLR   = 4'd6;
  localparam logic [3:0] S_RANK   = 4'd7;
  localparam logic [3:0] S_T1     = 4'd8;
  localparam logic [3:0] S_W1     = 4'd9;
  localparam logic [3:0] S_W2     = 4'd10;
  localparam logic [3:0] S_W3     = 4'd11;
  localparam logic [3:0] S_APPLY  = 4'd12;

  lbs_pkg::lbs_entry_t e_q [ENTRIES];
  logic [CW-1:0]       rank_q [ENTRIES];
  lbs_pkg::lbs_entry_t ret_e;
  logic [CW-1:0]       ret_rank;
  logic                shift, clr;
  lbs_pkg::lbs_bcast_t bc;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      lbs_pkg::lbs_entry_t nb_e;
      logic [CW-1:0]       nb_rank;
      if (gi == ENTRIES - 1) begin : g_tail
        assign nb_e    = ret_e;
        assign nb_rank = ret_rank;
      end else begin : g_mid
        assign nb_e    = e_q[gi+1];
        assign nb_rank = rank_q[gi+1];
      end
      lbs_cell #(.RW(CW)) u_cell (
        .clk    (clk),
        .shift  (shift),
        .clr    (clr),
        .bc     (bc),
        .ent_i  (nb_e),
        .rank_i (nb_rank),
        .ent_o  (e_q[gi]),
        .rank_o (rank_q[gi])
      );
    end
  endgenerate

  logic                          div_start, div_done;
  logic [lbs_pkg::DIV_AW-1:0]    div_a, div_q;
  logic [lbs_pkg::DIV_BW-1:0]    div_b;

  lbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  lbs_pkg::lbs_in_t    in_r;
  logic                found_r, found_nxt;
  logic [CW-1:0]       m_r, m_nxt;
  logic [3:0]          grp_r, grp_nxt;
  lbs_pkg::lbs_entry_t hold_r, hold_nxt;
  logic [3:0]          g_r, g_nxt;
  logic                rebuild_r, rebuild_nxt;
  logic                first_r, first_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [31:0]         sh_cf_r, sh_cf_nxt;
  logic [15:0]         sh_adj_r, sh_adj_nxt;
  logic [10:0]         on_r, on_nxt, off_r, off_nxt, p_r, p_nxt;
  logic [lbs_pkg::DIV_AW-1:0] x_r, x_nxt, y_r, y_nxt;
  lbs_pkg::lbs_out_t   pend_r, pend_nxt, out_r, out_nxt;

  lbs_pkg::lbs_entry_t head, upd, app_e, grp_e;
  logic [CW-1:0]       head_rank;
  logic                last_pass, hv, out_free, expd, match, mode_ok;
  logic [31:0]         diff, cf_in;
  logic [15:0]         adj_in;
  logic [11:0]         wait_t;
  logic [7:0]          fade_v;
  logic [CW:0]         mul_a;
  logic [CW+11:0]      prod;
  lbs_pkg::lbs_out_t   res;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    head      = e_q[0];
    head_rank = rank_q[0];
    last_pass = idx_r == CW'(ENTRIES - 1);
    hv        = idx_r < count_r;
    out_free  = !out_valid_r || !out_stall;
    cf_in     = {in_r.red_in, in_r.green_in, in_r.blue_in, in_r.fade_in};
    adj_in    = {in_r.duty_adjust, in_r.period_adjust};
    mode_ok   = (in_r.anim_mode != lbs_pkg::MODE_STOP) &&
                (in_r.anim_mode <= lbs_pkg::MODE_MQ_ADJ);
    match     = hv && (head.led == in_r.led_index);

    // A deadline has passed when the signed distance to it is above zero.
    diff = in_r.now_ms - head.deadline;
    expd = hv && (diff != 32'd0) && !diff[31];

    upd = head;
    if (!head.phase) begin
      fade_v    = head.color_fade[7:0];
      upd.phase = 1'b1;
      wait_t    = head.on_time;
    end else begin
      fade_v    = lbs_pkg::FADE_DARK;
      upd.phase = 1'b0;
      wait_t    = head.off_time;
    end
    if (head.mode == lbs_pkg::MODE_BURST) begin
      upd.on_time = lbs_pkg::burst_next(head.on_time);
      wait_t      = upd.on_time;
    end
    upd.deadline = head.deadline + 32'(wait_t);

    res.led_out   = head.led;
    res.red_out   = head.color_fade[31:24];
    res.green_out = head.color_fade[23:16];
    res.blue_out  = head.color_fade[15:8];
    res.fade_out  = fade_v;
    res.last      = 1'b0;

    app_e.led        = in_r.led_index;
    app_e.mode       = in_r.anim_mode;
    app_e.phase      = 1'b0;
    app_e.color_fade = cf_in;
    app_e.adjusts    = adj_in;
    app_e.deadline   = in_r.now_ms;
    app_e.on_time    = lbs_pkg::half_period(in_r.anim_mode);
    app_e.off_time   = app_e.on_time;

    mul_a = {1'b0, head_rank} + (CW+1)'(1);
    prod  = mul_a * on_r;
    grp_e            = head;
    grp_e.color_fade = sh_cf_r;
    grp_e.adjusts    = sh_adj_r;
    grp_e.on_time    = {1'b0, on_r};
    grp_e.off_time   = {1'b0, off_r};
    grp_e.deadline   = in_r.now_ms + 32'(prod);
    grp_e.phase      = 1'b0;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    found_nxt     = found_r;
    m_nxt         = m_r;
    grp_nxt       = grp_r;
    hold_nxt      = hold_r;
    g_nxt         = g_r;
    rebuild_nxt   = rebuild_r;
    first_nxt     = first_r;
    n_nxt         = n_r;
    sh_cf_nxt     = sh_cf_r;
    sh_adj_nxt    = sh_adj_r;
    on_nxt        = on_r;
    off_nxt       = off_r;
    p_nxt         = p_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    shift         = 1'b0;
    clr           = 1'b0;
    ret_e         = head;
    ret_rank      = head_rank;
    bc            = '0;
    div_start     = 1'b0;
    div_a         = '0;
    div_b         = '0;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          if (!in_data.action) begin
            state_nxt = S_TICK;
          end else begin
            found_nxt = 1'b0;
            grp_nxt   = lbs_pkg::MODE_STOP;
            state_nxt = S_REMA;
          end
        end
      end

      S_TICK: begin
        // A new write may only displace the held one when the output can take it.
        if (!(expd && pend_v_r && !out_free)) begin
          shift   = 1'b1;
          idx_nxt = last_pass ? '0 : idx_r + CW'(1);
          if (expd) begin
            ret_e = upd;
            if (pend_v_r) begin
              out_nxt       = pend_r;
              out_valid_nxt = 1'b1;
            end
            pend_nxt   = res;
            pend_v_nxt = 1'b1;
          end
          if (last_pass) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      S_REMA: begin
        shift   = 1'b1;
        idx_nxt = last_pass ? '0 : idx_r + CW'(1);
        if (match && !found_r) begin
          found_nxt = 1'b1;
          m_nxt     = idx_r;
          if (head.mode >= lbs_pkg::MODE_MQ_DESC && head.mode <= lbs_pkg::MODE_MQ_ADJ) begin
            grp_nxt = head.mode;
          end
        end
        if (hv && idx_r == count_r - CW'(1)) begin
          hold_nxt = head;
        end
        if (last_pass) begin
          if (found_nxt) begin
            state_nxt = S_REMB;
          end else if (mode_ok && count_r < CW'(ENTRIES)) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_REMB: begin
        shift   = 1'b1;
        idx_nxt = last_pass ? '0 : idx_r + CW'(1);
        if (idx_r == m_r && m_r != count_r - CW'(1)) begin
          ret_e = hold_r;
        end
        if (last_pass) begin
          count_nxt = count_r - CW'(1);
          if (grp_r != lbs_pkg::MODE_STOP) begin
            g_nxt       = grp_r;
            rebuild_nxt = 1'b1;
            state_nxt   = S_BCLR;
          end else if (mode_ok) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_APPEND: begin
        shift   = 1'b1;
        idx_nxt = last_pass ? '0 : idx_r + CW'(1);
        if (idx_r == count_r) begin
          ret_e = app_e;
        end
        if (last_pass) begin
          count_nxt = count_r + CW'(1);
          if (in_r.anim_mode >= lbs_pkg::MODE_MQ_DESC) begin
            g_nxt       = in_r.anim_mode;
            rebuild_nxt = 1'b0;
            sh_cf_nxt   = cf_in;
            sh_adj_nxt  = adj_in;
            state_nxt   = S_BCLR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_BCLR: begin
        clr       = 1'b1;
        n_nxt     = '0;
        first_nxt = 1'b1;
        state_nxt = S_RANK;
      end

      S_RANK: begin
        shift    = 1'b1;
        idx_nxt  = last_pass ? '0 : idx_r + CW'(1);
        bc.valid = hv && (head.mode == g_r);
        bc.led   = head.led;
        bc.mode  = g_r;
        if (bc.valid) begin
          n_nxt = n_r + CW'(1);
          if (rebuild_r && first_r) begin
            sh_cf_nxt  = head.color_fade;
            sh_adj_nxt = head.adjusts;
            first_nxt  = 1'b0;
          end
        end
        if (last_pass) begin
          if (n_nxt == '0) begin
            if (rebuild_r && mode_ok && count_r < CW'(ENTRIES)) begin
              state_nxt = S_APPEND;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_T1;
          end
        end
      end

      S_T1: begin
        if (g_r != lbs_pkg::MODE_MQ_ADJ && n_r <= CW'(1)) begin
          on_nxt    = lbs_pkg::T_HALF;
          off_nxt   = lbs_pkg::T_HALF;
          state_nxt = S_APPLY;
        end else if (g_r == lbs_pkg::MODE_MQ_ADJ) begin
          x_nxt     = lbs_pkg::DIV_AW'(sh_adj_r[7:0]) * lbs_pkg::DIV_AW'(lbs_pkg::T_PERIOD);
          state_nxt = S_W1;
        end else begin
          div_start = 1'b1;
          div_a     = lbs_pkg::DIV_AW'(lbs_pkg::T_SPAN);
          div_b     = lbs_pkg::DIV_BW'(n_r);
          state_nxt = S_W1;
        end
      end

      S_W1: begin
        case (g_r)
          lbs_pkg::MODE_MQ_ADJ: begin
            p_nxt     = lbs_pkg::div255(x_r);
            state_nxt = S_W2;
          end
          lbs_pkg::MODE_MQ_DESC: begin
            if (div_done) begin
              off_nxt   = div_q[10:0];
              on_nxt    = lbs_pkg::T_SPAN - div_q[10:0];
              state_nxt = S_APPLY;
            end
          end
          default: begin
            if (div_done) begin
              on_nxt    = div_q[10:0];
              off_nxt   = lbs_pkg::T_HALF;
              state_nxt = S_APPLY;
            end
          end
        endcase
      end

      S_W2: begin
        x_nxt     = lbs_pkg::DIV_AW'(p_r) *
                    lbs_pkg::DIV_AW'(lbs_pkg::ADJ_FULL - sh_adj_r[15:8]);
        y_nxt     = lbs_pkg::DIV_AW'(p_r) * lbs_pkg::DIV_AW'(sh_adj_r[15:8]);
        state_nxt = S_W3;
      end

      S_W3: begin
        on_nxt    = lbs_pkg::div255(x_r);
        off_nxt   = lbs_pkg::div255(y_r);
        state_nxt = S_APPLY;
      end

      S_APPLY: begin
        shift   = 1'b1;
        idx_nxt = last_pass ? '0 : idx_r + CW'(1);
        if (hv && head.mode == g_r) begin
          ret_e = grp_e;
        end
        if (last_pass) begin
          if (rebuild_r && mode_ok && count_r < CW'(ENTRIES)) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      in_r <= in_data;
    end
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
    found_r   <= found_nxt;
    m_r       <= m_nxt;
    grp_r     <= grp_nxt;
    hold_r    <= hold_nxt;
    g_r       <= g_nxt;
    rebuild_r <= rebuild_nxt;
    first_r   <= first_nxt;
    n_r       <= n_nxt;
    sh_cf_r   <= sh_cf_nxt;
    sh_adj_r  <= sh_adj_nxt;
    on_r      <= on_nxt;
    off_r     <= off_nxt;
    p_r       <= p_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/lbs_cell.sv
// One table slot of the rotating entry ring, with its local group rank counter.
`default_nettype none
module lbs_cell #(
  parameter int RW = 6
) (
  input  wire logic               clk,
  input  wire logic               shift,
  input  wire logic               clr,
  input  wire lbs_pkg::lbs_bcast_t bc,
  input  wire lbs_pkg::lbs_entry_t ent_i,
  input  wire logic [RW-1:0]      rank_i,
  output lbs_pkg::lbs_entry_t     ent_o,
  output logic [RW-1:0]           rank_o
);

  lbs_pkg::lbs_entry_t ent_r;
  logic [RW-1:0]       rank_r;
  logic                ahead;
  logic                inc;

  always_comb begin
    if (bc.mode == lbs_pkg::MODE_MQ_DESC) begin
      ahead = bc.led > ent_r.led;
    end else begin
      ahead = bc.led < ent_r.led;
    end
    inc    = bc.valid && (ent_r.mode == bc.mode) && ahead;
    rank_o = rank_r + RW'(inc);
    ent_o  = ent_r;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      rank_r <= '0;
    end else if (shift) begin
      ent_r  <= ent_i;
      rank_r <= rank_i;
    end else begin
      rank_r <= rank_o;
    end
  end

endmodule
`default_nettype wire

>>> rtl/lbs_div.sv
// Restoring divider, one quotient bit per cycle, used for the marquee timings.
`default_nettype none
module lbs_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [lbs_pkg::DIV_AW-1:0]  a,
  input  wire logic [lbs_pkg::DIV_BW-1:0]  b,
  output logic                             done,
  output logic [lbs_pkg::DIV_AW-1:0]       q
);

  localparam int AW = lbs_pkg::DIV_AW;
  localparam int BW = lbs_pkg::DIV_BW;
  localparam int CNW = $clog2(AW + 1);

  logic [BW-1:0]  rem_r, rem_nxt;
  logic [AW-1:0]  dq_r, dq_nxt;
  logic [BW-1:0]  b_r;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic [BW:0]    r2;
  logic           qbit;

  always_comb begin
    r2   = {rem_r, dq_r[AW-1]};
    qbit = r2 >= {1'b0, b_r};
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      dq_nxt  = a;
      cnt_nxt = CNW'(AW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = qbit ? BW'(r2 - {1'b0, b_r}) : r2[BW-1:0];
      dq_nxt  = {dq_r[AW-2:0], qbit};
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    if (start) begin
      b_r <= b;
    end
  end

  assign done = done_r;
  assign q    = dq_r;

endmodule
`default_nettype wire
